>>> rtl/jdv_pkg.sv
// Shared constants, types and helper functions for the joint distance vote detector.
// No dependencies; jdv_mac, jdv_sqrt, the top level and the testbench import this package.
package jdv_pkg;

   localparam int NUM_JOINTS = 18;
   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS = 4;

   localparam int DIST_BITS = 18;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
   localparam int WEIGHT_BITS = 16;
   localparam int CONF_BITS = 8;
   localparam int COUNT_BITS = 5;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam int INDEX_BITS = 5;

   localparam int JIDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int TABLE_DEPTH = 2 * NUM_JOINTS;
   localparam int TADDR_W = $clog2(TABLE_DEPTH);
   localparam int TABLE_W = 2 * DIST_BITS;

   localparam int DX_W = COORD_BITS + 3;
   localparam int MAG_W = COORD_BITS + 2;
   localparam int SUMSQ_W = 2 * MAG_W + 1;
   localparam int RAD_W = SUMSQ_W + 2 * FRAC_BITS;
   localparam int ROOT_W = (RAD_W + 1) / 2;
   localparam int RAD_PAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;
   localparam int SQRT_CNT_W = $clog2(ROOT_W);
   localparam int WIDE_W = (ROOT_W > DIST_BITS) ? ROOT_W : DIST_BITS;

   localparam int MUL_W0 = (DIST_BITS > MAG_W) ? DIST_BITS : MAG_W;
   localparam int MUL_W = (MUL_W0 > WEIGHT_BITS + 1) ? MUL_W0 : WEIGHT_BITS + 1;
   localparam int ACC_W = 2 * MUL_W + 2;
   localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(2 ** (WEIGHT_BITS - 1));
   localparam logic [WEIGHT_BITS:0] WEIGHT_ONE = (WEIGHT_BITS + 1)'(2 ** WEIGHT_BITS);

   localparam int OFF_JIDX = 0;
   localparam int OFF_JX = OFF_JIDX + INDEX_BITS;
   localparam int OFF_JY = OFF_JX + COORD_BITS;
   localparam int OFF_CONF = OFF_JY + COORD_BITS;
   localparam int OFF_BL = OFF_CONF + CONF_BITS;
   localparam int OFF_BT = OFF_BL + COORD_BITS + 1;
   localparam int OFF_BW = OFF_BT + COORD_BITS + 1;
   localparam int OFF_BH = OFF_BW + COORD_BITS;
   localparam int REQ_DATA_RAW = OFF_BH + COORD_BITS;
   localparam int REQ_DATA_W = ((REQ_DATA_RAW + 7) / 8) * 8;
   localparam int REQ_USER_W = 2;
   localparam int TUSER_TYPE = 0;
   localparam int TUSER_SEL = 1;

   localparam int RSP_DATA_RAW = 1 + 2 * COUNT_BITS;
   localparam int RSP_DATA_W = ((RSP_DATA_RAW + 7) / 8) * 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic {
      REQ_JOINT = 1'b0,
      REQ_CLEAR = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CONF_TRACK  = 3'd0,
      CSR_CONF_INIT   = 3'd1,
      CSR_LEARN_RATE  = 3'd2,
      CSR_SPREAD_FRAC = 3'd3,
      CSR_MIN_JOINTS  = 3'd4,
      CSR_VOTE_RATIO  = 3'd5
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_JOINT,
      ST_INIT_MUL,
      ST_INIT_WR,
      ST_FRAME_END,
      ST_DET_MUL,
      ST_EMIT,
      ST_UPD_RD,
      ST_UPD_CAP,
      ST_MEAN_MUL0,
      ST_MEAN_MUL1,
      ST_SPR_MUL0,
      ST_SPR_MUL1,
      ST_UPD_WR,
      ST_FRAME_CLR
   } state_type;

   typedef struct packed {
      logic en;
      logic load;
      logic rnd;
   } mac_op_type;

   function automatic logic [DIST_BITS-1:0] sat_dist(input logic [ROOT_W-1:0] root);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(root);
      if (wide > WIDE_W'(DIST_MAX)) begin
         return DIST_MAX;
      end
      return wide[DIST_BITS-1:0];
   endfunction

endpackage

>>> rtl/jdv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jdv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/jdv_mac.sv
// Shared multiply-accumulate unit: squares, blends, spread seed and vote product.
// Depends on jdv_pkg.
module jdv_mac import jdv_pkg::*; (
   input  logic             clock,
   input  mac_op_type       op,
   input  logic [MUL_W-1:0] mul_a,
   input  logic [MUL_W-1:0] mul_b,
   output logic [ACC_W-1:0] acc
);

   logic [2*MUL_W-1:0] product;
   logic [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]   acc_in;

   always_comb begin
      product = mul_a * mul_b;
      acc_in = (op.load ? '0 : acc_ff) + ACC_W'(product) + (op.rnd ? ROUND_BIAS : '0);
   end

   always_ff @(posedge clock) begin
      if (op.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

>>> rtl/jdv_sqrt.sv
// Iterative integer square root, one root bit per cycle.
// Depends on jdv_pkg.
module jdv_sqrt import jdv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RAD_PAD_W-1:0] radicand,
   output logic [ROOT_W-1:0]    root,
   output logic                 done
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RAD_PAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [ROOT_W-1:0]     root_ff;
   logic [REM_W-1:0]      rem_sh;
   logic [REM_W-1:0]      trial;
   logic [REM_W-1:0]      diff;
   logic                  fits;

   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_PAD_W-1 -: 2]};
      trial = {root_ff, 2'b01};
      diff = rem_sh - trial;
      fits = (rem_sh >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = SQRT_CNT_W'(ROOT_W - 1);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff <= radicand;
         rem_ff <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= rad_ff << 2;
         rem_ff <= fits ? diff : rem_sh;
         root_ff <= {root_ff[ROOT_W-2:0], fits};
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

>>> rtl/joint_distance_vote_detector.sv
// Top level of the joint distance vote detector: sequencer, learned tables, frame store.
// Depends on jdv_pkg, jdv_ram, jdv_mac and jdv_sqrt.
//
// One body joint per request beat. A confident joint runs two multiply-accumulate steps for
// the squared distance to the box center, then the bit-serial square root (one root bit per
// cycle, 19 bits here); a joint that first learns its mean seeds its spread through the
// multiplier and writes the table. A joint at or below the tracking threshold or out of
// range skips the distance, and a table clear drops the valid bits of both tables. A joint
// beat marked last adds the vote and, without a detection, a sweep of the 18 entries of the
// selected table in the shared multiplier, blending each trained mean and, if its frame
// excess is nonzero, its spread. A response held off by the receiver stalls the vote step
// until it leaves. The learned tables and the frame store sit in RAM with one valid bit
// per entry, so reset needs no clearing pass. The block takes no request beat while it
// works; a response waits in its own register and the next request is taken while it does.
module joint_distance_vote_detector import jdv_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // joint_index, joint_x, joint_y, joint_conf, box_left, box_top, box_width, box_height
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // req_type, table_sel
   input  logic [REQ_USER_W-1:0]  req_tuser,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // detected, vote_total, counted_total
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   state_type state_ff, state_in;

   logic [CONF_BITS-1:0]   conf_track_ff;
   logic [CONF_BITS-1:0]   conf_init_ff;
   logic [WEIGHT_BITS-1:0] learn_rate_ff;
   logic [WEIGHT_BITS-1:0] spread_frac_ff;
   logic [COUNT_BITS-1:0]  min_joints_ff;
   logic [COUNT_BITS-1:0]  vote_ratio_ff;

   logic [JIDX_W-1:0]       jidx_ff;
   logic [COORD_BITS-1:0]   jx_ff, jy_ff;
   logic [CONF_BITS-1:0]    conf_ff;
   logic [COORD_BITS:0]     bl_ff, bt_ff;
   logic [COORD_BITS-1:0]   bw_ff, bh_ff;
   logic                    sel_ff;
   logic                    last_ff;

   logic [DIST_BITS-1:0]    mean_ff, spread_ff, dist_ff, excess_ff, new_mean_ff;
   logic [COUNT_BITS-1:0]   vote_ff, vote_in;
   logic [COUNT_BITS-1:0]   joint_ff, joint_in;
   logic [JIDX_W-1:0]       jcnt_ff, jcnt_in;
   logic [TABLE_DEPTH-1:0]  tbl_valid_ff, tbl_valid_in;
   logic [NUM_JOINTS-1:0]   frm_valid_ff, frm_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic                    rsp_load;

   logic [INDEX_BITS-1:0]   f_jidx;
   logic [CONF_BITS-1:0]    f_conf;
   logic                    f_used;

   logic [JIDX_W-1:0]       row;
   logic [TADDR_W-1:0]      tidx;
   logic [MAG_W-1:0]        mag_x, mag_y;
   logic [DIST_BITS-1:0]    excess_calc;
   logic [DIST_BITS-1:0]    mean_rd, spread_rd, fdist_rd, fexc_rd;
   logic [WEIGHT_BITS:0]    weight_new;
   logic [DIST_BITS-1:0]    blend_out;
   logic                    det;
   logic                    vote_hit;

   mac_op_type              mac_op;
   logic [MUL_W-1:0]        mac_a, mac_b;
   logic [ACC_W-1:0]        mac_acc;
   logic                    sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]       sqrt_root;
   logic [RAD_PAD_W-1:0]    radicand;

   logic                    tbl_rd_en, tbl_wr_en;
   logic [TABLE_W-1:0]      tbl_wr_data, tbl_rd_data;
   logic                    frm_rd_en, frm_wr_en;
   logic [TABLE_W-1:0]      frm_wr_data, frm_rd_data;

   function automatic logic [MAG_W-1:0] abs_offset(
      input logic [COORD_BITS-1:0] pos,
      input logic [COORD_BITS:0]   lo_edge,
      input logic [COORD_BITS-1:0] size
   );
      logic signed [DX_W-1:0] center;
      logic signed [DX_W-1:0] offset;
      logic [DX_W-1:0]        negated;
      center = $signed({{2{lo_edge[COORD_BITS]}}, lo_edge}) +
               $signed({4'b0000, size[COORD_BITS-1:1]});
      offset = $signed({3'b000, pos}) - center;
      negated = -offset;
      return offset[DX_W-1] ? negated[MAG_W-1:0] : offset[MAG_W-1:0];
   endfunction

   jdv_mac u_mac (
      .clock (clock),
      .op    (mac_op),
      .mul_a (mac_a),
      .mul_b (mac_b),
      .acc   (mac_acc)
   );

   jdv_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .root     (sqrt_root),
      .done     (sqrt_done)
   );

   jdv_ram #(.WIDTH(TABLE_W), .DEPTH(TABLE_DEPTH)) u_table_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tidx),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tidx),
      .rd_data (tbl_rd_data)
   );

   jdv_ram #(.WIDTH(TABLE_W), .DEPTH(NUM_JOINTS)) u_frame_ram (
      .clock   (clock),
      .wr_en   (frm_wr_en),
      .wr_addr (row),
      .wr_data (frm_wr_data),
      .rd_en   (frm_rd_en),
      .rd_addr (row),
      .rd_data (frm_rd_data)
   );

   always_comb begin
      f_jidx = req_tdata[OFF_JIDX +: INDEX_BITS];
      f_conf = req_tdata[OFF_CONF +: CONF_BITS];
      f_used = ({1'b0, f_jidx} < (INDEX_BITS + 1)'(NUM_JOINTS)) && (f_conf > conf_track_ff);

      if (state_ff == ST_UPD_RD || state_ff == ST_UPD_CAP || state_ff == ST_UPD_WR) begin
         row = jcnt_ff;
      end else begin
         row = jidx_ff;
      end
      tidx = sel_ff ? TADDR_W'(NUM_JOINTS) + TADDR_W'(row) : TADDR_W'(row);

      mag_x = abs_offset(jx_ff, bl_ff, bw_ff);
      mag_y = abs_offset(jy_ff, bt_ff, bh_ff);
      radicand = RAD_PAD_W'(mac_acc[SUMSQ_W-1:0]) << (2 * FRAC_BITS);

      excess_calc = (dist_ff > mean_ff) ? dist_ff - mean_ff : '0;
      vote_hit = ({1'b0, excess_calc} > {spread_ff, 1'b0});
      mean_rd = tbl_valid_ff[tidx] ? tbl_rd_data[DIST_BITS-1:0] : '0;
      spread_rd = tbl_valid_ff[tidx] ? tbl_rd_data[TABLE_W-1:DIST_BITS] : '0;
      fdist_rd = frm_valid_ff[row] ? frm_rd_data[DIST_BITS-1:0] : '0;
      fexc_rd = frm_valid_ff[row] ? frm_rd_data[TABLE_W-1:DIST_BITS] : '0;
      weight_new = WEIGHT_ONE - {1'b0, learn_rate_ff};
      blend_out = mac_acc[WEIGHT_BITS +: DIST_BITS];
      det = (mac_acc > ACC_W'(joint_ff)) && (joint_ff > min_joints_ff);
   end

   always_comb begin
      state_in = state_ff;
      req_tready = 1'b0;
      mac_op = '0;
      mac_a = '0;
      mac_b = '0;
      sqrt_start = 1'b0;
      tbl_rd_en = 1'b0;
      tbl_wr_en = 1'b0;
      tbl_wr_data = {spread_ff, dist_ff};
      frm_rd_en = 1'b0;
      frm_wr_en = 1'b0;
      frm_wr_data = {excess_calc, dist_ff};
      tbl_valid_in = tbl_valid_ff;
      frm_valid_in = frm_valid_ff;
      vote_in = vote_ff;
      joint_in = joint_ff;
      jcnt_in = jcnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_load = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser[TUSER_TYPE] == REQ_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (f_used) begin
                  state_in = ST_SQ_X;
               end else begin
                  state_in = ST_FRAME_END;
               end
            end
         end
         ST_CLEAR: begin
            tbl_valid_in = '0;
            state_in = ST_IDLE;
         end
         ST_SQ_X: begin
            mac_op = '{en: 1'b1, load: 1'b1, rnd: 1'b0};
            mac_a = MUL_W'(mag_x);
            mac_b = MUL_W'(mag_x);
            tbl_rd_en = 1'b1;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            mac_op = '{en: 1'b1, load: 1'b0, rnd: 1'b0};
            mac_a = MUL_W'(mag_y);
            mac_b = MUL_W'(mag_y);
            state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            sqrt_start = 1'b1;
            state_in = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (sqrt_done) begin
               state_in = ST_JOINT;
            end
         end
         ST_JOINT: begin
            frm_wr_en = 1'b1;
            frm_valid_in[row] = 1'b1;
            state_in = ST_FRAME_END;
            if (mean_ff == '0) begin
               if (conf_ff > conf_init_ff) begin
                  state_in = ST_INIT_MUL;
               end
            end else begin
               if (vote_hit && vote_ff != COUNT_MAX) begin
                  vote_in = vote_ff + 1'b1;
               end
               if (joint_ff != COUNT_MAX) begin
                  joint_in = joint_ff + 1'b1;
               end
            end
         end
         ST_INIT_MUL: begin
            mac_op = '{en: 1'b1, load: 1'b1, rnd: 1'b1};
            mac_a = MUL_W'(dist_ff);
            mac_b = MUL_W'(spread_frac_ff);
            state_in = ST_INIT_WR;
         end
         ST_INIT_WR: begin
            tbl_wr_en = 1'b1;
            tbl_wr_data = {blend_out, dist_ff};
            tbl_valid_in[tidx] = 1'b1;
            state_in = ST_FRAME_END;
         end
         ST_FRAME_END: begin
            state_in = last_ff ? ST_DET_MUL : ST_IDLE;
         end
         ST_DET_MUL: begin
            mac_op = '{en: 1'b1, load: 1'b1, rnd: 1'b0};
            mac_a = MUL_W'(vote_ff);
            mac_b = MUL_W'(vote_ratio_ff);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               jcnt_in = '0;
               state_in = det ? ST_FRAME_CLR : ST_UPD_RD;
            end
         end
         ST_UPD_RD: begin
            tbl_rd_en = 1'b1;
            frm_rd_en = 1'b1;
            state_in = ST_UPD_CAP;
         end
         ST_UPD_CAP: begin
            if (mean_rd == '0) begin
               if (jcnt_ff == JIDX_W'(NUM_JOINTS - 1)) begin
                  state_in = ST_FRAME_CLR;
               end else begin
                  jcnt_in = jcnt_ff + 1'b1;
                  state_in = ST_UPD_RD;
               end
            end else begin
               state_in = ST_MEAN_MUL0;
            end
         end
         ST_MEAN_MUL0: begin
            mac_op = '{en: 1'b1, load: 1'b1, rnd: 1'b1};
            mac_a = MUL_W'(mean_ff);
            mac_b = MUL_W'(learn_rate_ff);
            state_in = ST_MEAN_MUL1;
         end
         ST_MEAN_MUL1: begin
            mac_op = '{en: 1'b1, load: 1'b0, rnd: 1'b0};
            mac_a = MUL_W'(dist_ff);
            mac_b = MUL_W'(weight_new);
            state_in = ST_SPR_MUL0;
         end
         ST_SPR_MUL0: begin
            if (excess_ff != '0) begin
               mac_op = '{en: 1'b1, load: 1'b1, rnd: 1'b1};
               mac_a = MUL_W'(spread_ff);
               mac_b = MUL_W'(learn_rate_ff);
               state_in = ST_SPR_MUL1;
            end else begin
               state_in = ST_UPD_WR;
            end
         end
         ST_SPR_MUL1: begin
            mac_op = '{en: 1'b1, load: 1'b0, rnd: 1'b0};
            mac_a = MUL_W'(excess_ff);
            mac_b = MUL_W'(weight_new);
            state_in = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            tbl_wr_en = 1'b1;
            tbl_wr_data = {((excess_ff != '0) ? blend_out : spread_ff), new_mean_ff};
            if (jcnt_ff == JIDX_W'(NUM_JOINTS - 1)) begin
               state_in = ST_FRAME_CLR;
            end else begin
               jcnt_in = jcnt_ff + 1'b1;
               state_in = ST_UPD_RD;
            end
         end
         ST_FRAME_CLR: begin
            frm_valid_in = '0;
            vote_in = '0;
            joint_in = '0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tbl_valid_ff <= '0;
         frm_valid_ff <= '0;
         vote_ff <= '0;
         joint_ff <= '0;
         jcnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         conf_track_ff <= CONF_BITS'(76);
         conf_init_ff <= CONF_BITS'(128);
         learn_rate_ff <= WEIGHT_BITS'(62259);
         spread_frac_ff <= WEIGHT_BITS'(3277);
         min_joints_ff <= COUNT_BITS'(8);
         vote_ratio_ff <= COUNT_BITS'(3);
      end else begin
         state_ff <= state_in;
         tbl_valid_ff <= tbl_valid_in;
         frm_valid_ff <= frm_valid_in;
         vote_ff <= vote_in;
         joint_ff <= joint_in;
         jcnt_ff <= jcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_CONF_TRACK:  conf_track_ff <= csr_data[CONF_BITS-1:0];
               CSR_CONF_INIT:   conf_init_ff <= csr_data[CONF_BITS-1:0];
               CSR_LEARN_RATE:  learn_rate_ff <= csr_data[WEIGHT_BITS-1:0];
               CSR_SPREAD_FRAC: spread_frac_ff <= csr_data[WEIGHT_BITS-1:0];
               CSR_MIN_JOINTS:  min_joints_ff <= csr_data[COUNT_BITS-1:0];
               CSR_VOTE_RATIO:  vote_ratio_ff <= csr_data[COUNT_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         jidx_ff <= f_jidx[JIDX_W-1:0];
         jx_ff <= req_tdata[OFF_JX +: COORD_BITS];
         jy_ff <= req_tdata[OFF_JY +: COORD_BITS];
         conf_ff <= f_conf;
         bl_ff <= req_tdata[OFF_BL +: COORD_BITS + 1];
         bt_ff <= req_tdata[OFF_BT +: COORD_BITS + 1];
         bw_ff <= req_tdata[OFF_BW +: COORD_BITS];
         bh_ff <= req_tdata[OFF_BH +: COORD_BITS];
         sel_ff <= req_tuser[TUSER_SEL];
         last_ff <= req_tlast;
      end
      if (state_ff == ST_SQ_Y || state_ff == ST_UPD_CAP) begin
         mean_ff <= mean_rd;
         spread_ff <= spread_rd;
      end
      if (state_ff == ST_ROOT_WAIT && sqrt_done) begin
         dist_ff <= sat_dist(sqrt_root);
      end else if (state_ff == ST_UPD_CAP) begin
         dist_ff <= fdist_rd;
      end
      if (state_ff == ST_UPD_CAP) begin
         excess_ff <= fexc_rd;
      end
      if (state_ff == ST_SPR_MUL0) begin
         new_mean_ff <= blend_out;
      end
      if (rsp_load) begin
         rsp_data_ff <= RSP_DATA_W'({joint_ff, vote_ff, det});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for joint_distance_vote_detector: drives joint and clear beats,
// programs the CSRs between phases and checks every response against an in-bench predictor.
// Depends on jdv_pkg and the joint_distance_vote_detector RTL.
module tb_top import jdv_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      req_kind_type                kind;
      logic [INDEX_BITS-1:0]       jidx;
      logic [COORD_BITS-1:0]       joint_x;
      logic [COORD_BITS-1:0]       joint_y;
      logic [CONF_BITS-1:0]        conf;
      logic signed [COORD_BITS:0]  box_left;
      logic signed [COORD_BITS:0]  box_top;
      logic [COORD_BITS-1:0]       box_width;
      logic [COORD_BITS-1:0]       box_height;
      logic                        sel;
      logic                        last;
   } joint_beat_type;

   typedef struct packed {
      logic                  detected;
      logic [COUNT_BITS-1:0] votes;
      logic [COUNT_BITS-1:0] counted;
   } vote_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [REQ_USER_W-1:0]  req_tuser;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   bit idle_on = 1'b1;
   int rsp_hold_left = 0;
   int fail_count = 0;

   // predictor state
   logic [DIST_BITS-1:0]  mean_tab[TABLE_DEPTH];
   logic [DIST_BITS-1:0]  spread_tab[TABLE_DEPTH];
   logic [DIST_BITS-1:0]  frame_dist[NUM_JOINTS];
   logic [DIST_BITS-1:0]  frame_exc[NUM_JOINTS];
   logic [COUNT_BITS-1:0] vote_cnt;
   logic [COUNT_BITS-1:0] joint_cnt;
   logic [7:0]            cfg_track;
   logic [7:0]            cfg_init;
   logic [15:0]           cfg_rate;
   logic [15:0]           cfg_frac;
   logic [4:0]            cfg_min;
   logic [4:0]            cfg_ratio;
   vote_result_type       pending_votes[$];

   // stimulus scene
   int                         base_dx[NUM_JOINTS];
   int                         base_dy[NUM_JOINTS];
   logic signed [COORD_BITS:0] scene_left;
   logic signed [COORD_BITS:0] scene_top;
   logic [COORD_BITS-1:0]      scene_w;
   logic [COORD_BITS-1:0]      scene_h;
   logic                       scene_sel = 1'b0;

   joint_distance_vote_detector u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   function automatic longint unsigned int_root(input longint unsigned n);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int i = 24; i >= 0; i--) begin
         trial = r | (64'd1 << i);
         if (trial * trial <= n) begin
            r = trial;
         end
      end
      return r;
   endfunction

   function automatic logic [DIST_BITS-1:0] ewma(input logic [DIST_BITS-1:0] prev,
                                                 input logic [DIST_BITS-1:0] obs);
      longint unsigned p;
      longint unsigned o;
      longint unsigned r;
      longint unsigned acc;
      p = 64'(prev);
      o = 64'(obs);
      r = 64'(cfg_rate);
      acc = p * r + o * (64'd65536 - r) + 64'd32768;
      return acc[16 +: DIST_BITS];
   endfunction

   task automatic score_joint(input joint_beat_type b);
      longint          cx;
      longint          cy;
      longint          dx;
      longint          dy;
      longint unsigned sumsq;
      longint unsigned root;
      longint unsigned ex;
      longint unsigned sp;
      logic [DIST_BITS-1:0] distance;
      logic [DIST_BITS-1:0] mean;
      logic [DIST_BITS-1:0] exc;
      int              t;
      bit              det;
      vote_result_type res;
      if (b.kind == REQ_CLEAR) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            mean_tab[i] = '0;
            spread_tab[i] = '0;
         end
         return;
      end
      if (b.jidx < NUM_JOINTS && b.conf > cfg_track) begin
         cx = longint'(b.box_left) + longint'(b.box_width >> 1);
         cy = longint'(b.box_top) + longint'(b.box_height >> 1);
         dx = longint'(b.joint_x) - cx;
         dy = longint'(b.joint_y) - cy;
         sumsq = dx * dx + dy * dy;
         root = int_root(sumsq << (2 * FRAC_BITS));
         distance = (root > DIST_MAX) ? DIST_MAX : root[DIST_BITS-1:0];
         t = int'(b.sel) * NUM_JOINTS + int'(b.jidx);
         mean = mean_tab[t];
         exc = (distance > mean) ? distance - mean : '0;
         frame_dist[b.jidx] = distance;
         frame_exc[b.jidx] = exc;
         if (mean == '0) begin
            if (b.conf > cfg_init) begin
               ex = 64'(distance);
               ex = (ex * cfg_frac + 64'd32768) >> 16;
               mean_tab[t] = distance;
               spread_tab[t] = ex[DIST_BITS-1:0];
            end
         end else begin
            ex = 64'(exc);
            sp = 64'(spread_tab[t]);
            if (ex > 2 * sp && vote_cnt != COUNT_MAX) begin
               vote_cnt++;
            end
            if (joint_cnt != COUNT_MAX) begin
               joint_cnt++;
            end
         end
      end
      if (!b.last) begin
         return;
      end
      det = (int'(vote_cnt) * int'(cfg_ratio) > int'(joint_cnt)) && (joint_cnt > cfg_min);
      res.detected = det;
      res.votes = vote_cnt;
      res.counted = joint_cnt;
      pending_votes.push_back(res);
      if (!det) begin
         for (int j = 0; j < NUM_JOINTS; j++) begin
            t = int'(b.sel) * NUM_JOINTS + j;
            if (mean_tab[t] != '0) begin
               mean_tab[t] = ewma(mean_tab[t], frame_dist[j]);
               if (frame_exc[j] > '0) begin
                  spread_tab[t] = ewma(spread_tab[t], frame_exc[j]);
               end
            end
         end
      end
      for (int j = 0; j < NUM_JOINTS; j++) begin
         frame_dist[j] = '0;
         frame_exc[j] = '0;
      end
      vote_cnt = '0;
      joint_cnt = '0;
   endtask

   always @(posedge clock) begin : check_votes
      vote_result_type want;
      vote_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.detected = rsp_tdata[0];
         got.votes = rsp_tdata[1 +: COUNT_BITS];
         got.counted = rsp_tdata[1 + COUNT_BITS +: COUNT_BITS];
         if (pending_votes.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got detected %0d votes %0d counted %0d",
                     $time, got.detected, got.votes, got.counted);
            fail_count++;
         end else begin
            want = pending_votes.pop_front();
            if (got.detected !== want.detected) begin
               $display("%0t: detected expected %0d got %0d", $time, want.detected, got.detected);
               fail_count++;
            end
            if (got.votes !== want.votes) begin
               $display("%0t: vote_total expected %0d got %0d", $time, want.votes, got.votes);
               fail_count++;
            end
            if (got.counted !== want.counted) begin
               $display("%0t: counted_total expected %0d got %0d", $time, want.counted,
                        got.counted);
               fail_count++;
            end
         end
      end
   end

   initial begin : rsp_ready_gen
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_beat(input joint_beat_type b);
      logic [REQ_DATA_W-1:0] data;
      logic [REQ_USER_W-1:0] user;
      data = '0;
      data[OFF_JIDX +: INDEX_BITS] = b.jidx;
      data[OFF_JX +: COORD_BITS] = b.joint_x;
      data[OFF_JY +: COORD_BITS] = b.joint_y;
      data[OFF_CONF +: CONF_BITS] = b.conf;
      data[OFF_BL +: COORD_BITS + 1] = b.box_left;
      data[OFF_BT +: COORD_BITS + 1] = b.box_top;
      data[OFF_BW +: COORD_BITS] = b.box_width;
      data[OFF_BH +: COORD_BITS] = b.box_height;
      user = '0;
      user[TUSER_TYPE] = b.kind;
      user[TUSER_SEL] = b.sel;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= user;
      req_tlast <= b.last;
      do @(posedge clock); while (!req_tready);
      score_joint(b);
      @(negedge clock);
   endtask

   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (pending_votes.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // drain, then let any resultless beat still in flight finish
   task automatic settle_block();
      wait_results_done();
      repeat (300) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CONF_TRACK:  cfg_track = val[7:0];
         CSR_CONF_INIT:   cfg_init = val[7:0];
         CSR_LEARN_RATE:  cfg_rate = val;
         CSR_SPREAD_FRAC: cfg_frac = val;
         CSR_MIN_JOINTS:  cfg_min = val[4:0];
         CSR_VOTE_RATIO:  cfg_ratio = val[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_regs(input int track, input int init, input int rate,
                               input int frac, input int minj, input int ratio);
      write_csr(CSR_CONF_TRACK, 16'(track));
      write_csr(CSR_CONF_INIT, 16'(init));
      write_csr(CSR_LEARN_RATE, 16'(rate));
      write_csr(CSR_SPREAD_FRAC, 16'(frac));
      write_csr(CSR_MIN_JOINTS, 16'(minj));
      write_csr(CSR_VOTE_RATIO, 16'(ratio));
   endtask

   function automatic joint_beat_type make_beat(input int idx, input int x, input int y,
                                                input int conf, input int left, input int top,
                                                input int w, input int h, input bit sel,
                                                input bit last);
      joint_beat_type b;
      b.kind = REQ_JOINT;
      b.jidx = idx[INDEX_BITS-1:0];
      b.joint_x = x[COORD_BITS-1:0];
      b.joint_y = y[COORD_BITS-1:0];
      b.conf = conf[CONF_BITS-1:0];
      b.box_left = left[COORD_BITS:0];
      b.box_top = top[COORD_BITS:0];
      b.box_width = w[COORD_BITS-1:0];
      b.box_height = h[COORD_BITS-1:0];
      b.sel = sel;
      b.last = last;
      return b;
   endfunction

   function automatic joint_beat_type random_beat();
      return make_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endfunction

   function automatic joint_beat_type make_clear(input bit sel, input bit last);
      joint_beat_type b;
      b = random_beat();
      b.kind = REQ_CLEAR;
      b.sel = sel;
      b.last = last;
      return b;
   endfunction

   function automatic int wobble_px(input int amount);
      return int'($urandom_range(0, 2 * amount)) - amount;
   endfunction

   function automatic logic [COORD_BITS-1:0] place(input longint pos);
      if (pos < 0) begin
         return '0;
      end
      if (pos > 4095) begin
         return '1;
      end
      return pos[COORD_BITS-1:0];
   endfunction

   function automatic joint_beat_type scene_beat(input logic [INDEX_BITS-1:0] idx,
                                                 input int wob);
      joint_beat_type b;
      int             j;
      longint         cx;
      longint         cy;
      j = (idx < NUM_JOINTS) ? int'(idx) : 0;
      cx = longint'(scene_left) + longint'(scene_w >> 1);
      cy = longint'(scene_top) + longint'(scene_h >> 1);
      b.kind = REQ_JOINT;
      b.jidx = idx;
      b.conf = ($urandom_range(0, 9) == 0) ? CONF_BITS'($urandom_range(0, 255)) :
                                             CONF_BITS'($urandom_range(140, 255));
      b.box_left = scene_left;
      b.box_top = scene_top;
      b.box_width = scene_w;
      b.box_height = scene_h;
      b.joint_x = place(cx + base_dx[j] + wobble_px(wob));
      b.joint_y = place(cy + base_dy[j] + wobble_px(wob));
      b.sel = scene_sel;
      b.last = 1'b0;
      return b;
   endfunction

   // move the subject and drop what the tables learned about the old scene
   task automatic new_scene();
      if ($urandom_range(0, 3) == 0) begin
         scene_left = (COORD_BITS + 1)'($urandom);
         scene_top = (COORD_BITS + 1)'($urandom);
         scene_w = COORD_BITS'($urandom);
         scene_h = COORD_BITS'($urandom);
      end else begin
         scene_left = (COORD_BITS + 1)'($urandom_range(0, 2000));
         scene_top = (COORD_BITS + 1)'($urandom_range(0, 2000));
         scene_w = COORD_BITS'($urandom_range(100, 1500));
         scene_h = COORD_BITS'($urandom_range(100, 1500));
      end
      for (int j = 0; j < NUM_JOINTS; j++) begin
         base_dx[j] = int'($urandom_range(0, 1600)) - 800;
         base_dy[j] = int'($urandom_range(0, 1600)) - 800;
      end
      send_beat(make_clear(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
   endtask

   // n of zero sends the joints in order, else n random indexes; noisy adds bad indexes
   task automatic send_frame(input int n, input int calm, input int wild, input bit noisy);
      joint_beat_type        b;
      int                    count;
      int                    wob;
      logic [INDEX_BITS-1:0] idx;
      count = (n == 0) ? NUM_JOINTS : n;
      for (int k = 0; k < count; k++) begin
         idx = (n == 0) ? INDEX_BITS'(k) : INDEX_BITS'($urandom_range(0, NUM_JOINTS - 1));
         if (noisy && $urandom_range(0, 9) == 0) begin
            idx = INDEX_BITS'($urandom_range(NUM_JOINTS, 31));
         end
         wob = (wild > 0 && $urandom_range(0, 2) != 0) ? wild : calm;
         b = scene_beat(idx, wob);
         if (noisy && k != count - 1 && $urandom_range(0, 7) == 0) begin
            b.sel = ~b.sel;
         end
         b.last = (k == count - 1);
         send_beat(b);
         if (noisy && $urandom_range(0, 29) == 0) begin
            send_beat(make_clear(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
         end
      end
   endtask

   task automatic test_directed();
      send_beat(make_beat(0, 4095, 4095, 255, -4096, -4096, 4095, 4095, 0, 0));
      send_beat(make_beat(17, 0, 0, 255, 4095, 4095, 0, 0, 1, 0));
      send_beat(make_beat(1, 100, 200, 128, 0, 0, 64, 64, 0, 0));
      send_beat(make_beat(2, 300, 40, 129, 0, 0, 64, 64, 0, 0));
      send_beat(make_beat(3, 500, 500, 76, 0, 0, 64, 64, 0, 0));
      send_beat(make_beat(31, 2000, 2000, 255, 0, 0, 64, 64, 0, 0));
      send_beat(make_beat(20, 10, 10, 255, 0, 0, 64, 64, 0, 1));
      send_beat(make_beat(0, 4095, 4095, 255, -4096, -4096, 4095, 4095, 0, 0));
      send_beat(make_beat(0, 0, 0, 255, -4096, -4096, 4095, 4095, 0, 0));
      send_beat(make_beat(2, 300, 40, 200, 0, 0, 64, 64, 0, 0));
      send_beat(make_beat(17, 4095, 4095, 255, 4095, 4095, 0, 0, 1, 0));
      send_beat(make_beat(5, 1234, 2345, 0, 100, 100, 10, 10, 0, 1));
      send_beat(make_clear(1'b0, 1'b1));
      send_beat(make_clear(1'b1, 1'b0));
      send_beat(make_beat(0, 4095, 4095, 255, -4096, -4096, 4095, 4095, 0, 1));
      send_beat(make_beat(0, 4095, 4095, 255, -4096, -4096, 4095, 4095, 0, 1));
   endtask

   task automatic test_register_sweep();
      for (int s = 0; s < 5; s++) begin
         settle_block();
         case (s)
            0: program_regs(0, 0, 0, 0, 0, 1);
            1: program_regs(255, 255, 65535, 65535, 31, 31);
            2: program_regs(30, 200, 32768, 20000, 4, 0);
            3: program_regs($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 31), $urandom_range(0, 31));
            default: program_regs(76, 128, 62259, 3277, 8, 3);
         endcase
         new_scene();
         for (int f = 0; f < 5; f++) begin
            send_frame((f == 3) ? $urandom_range(2, 10) : 0, 10,
                       (f % 2 == 1) ? 600 : 0, f == 4);
         end
      end
   endtask

   task automatic test_backpressure();
      joint_beat_type b;
      int             len;
      settle_block();
      new_scene();
      send_frame(0, 5, 0, 1'b0);
      rsp_hold_left = 400;
      for (int f = 0; f < 20; f++) begin
         len = $urandom_range(1, 3);
         for (int k = 0; k < len; k++) begin
            b = scene_beat(INDEX_BITS'($urandom_range(0, NUM_JOINTS - 1)),
                           $urandom_range(0, 300));
            b.last = (k == len - 1);
            send_beat(b);
         end
      end
      wait_results_done();
      for (int f = 0; f < 4; f++) begin
         send_frame(0, 10, (f == 2) ? 500 : 0, 1'b0);
      end
   endtask

   task automatic test_random_frames();
      int n;
      int wild;
      bit noisy;
      settle_block();
      program_regs(76, 128, 62259, 3277, 8, 3);
      new_scene();
      for (int f = 0; f < 50; f++) begin
         if (f == 25) begin
            settle_block();
            program_regs($urandom_range(0, 160), $urandom_range(0, 255),
                         $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 12), $urandom_range(1, 18));
         end
         if ($urandom_range(0, 14) == 0) begin
            new_scene();
         end
         if ($urandom_range(0, 9) == 0) begin
            scene_sel = ~scene_sel;
         end
         noisy = ($urandom_range(0, 9) < 3);
         case ($urandom_range(0, 7))
            0:       n = $urandom_range(1, NUM_JOINTS - 1);
            1:       n = noisy ? $urandom_range(32, 40) : 0;
            default: n = 0;
         endcase
         wild = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 800) : 0;
         send_frame(n, $urandom_range(0, 20), wild, noisy);
         if ($urandom_range(0, 5) == 0) begin
            send_beat(random_beat());
         end
      end
   endtask

   task automatic test_steady_stream();
      idle_on = 1'b0;
      for (int f = 0; f < 8; f++) begin
         send_frame(0, 10, (f % 3 == 0) ? 500 : 0, f == 5);
      end
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_CONF_TRACK;
      csr_data = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         mean_tab[i] = '0;
         spread_tab[i] = '0;
      end
      for (int j = 0; j < NUM_JOINTS; j++) begin
         frame_dist[j] = '0;
         frame_exc[j] = '0;
      end
      vote_cnt = '0;
      joint_cnt = '0;
      cfg_track = 8'd76;
      cfg_init = 8'd128;
      cfg_rate = 16'd62259;
      cfg_frac = 16'd3277;
      cfg_min = 5'd8;
      cfg_ratio = 5'd3;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_register_sweep();
      test_backpressure();
      test_random_frames();
      test_steady_stream();
      wait_results_done();
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d responses outstanding", pending_votes.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
